@@ sv/bve_pkg.sv @@
// Shared types and constants for the box volume block.
`default_nettype none
package bve_pkg;

  localparam int COORD_BITS = 16;
  localparam int LEN_W      = 17;
  localparam int VOL_W      = 3 * LEN_W;
  localparam int EDGE_W     = 2;
  localparam int ROOT_W     = COORD_BITS + 1;
  localparam int D2_W       = 2 * ROOT_W;
  localparam int CNT_W      = $clog2(ROOT_W);

  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(131071);
  localparam logic [EDGE_W-1:0] LAST_EDGE = EDGE_W'(2);

  localparam int AXIS_W = 2;
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         last_point;
  } in_word_t;

  typedef struct packed {
    logic [LEN_W-1:0]  edge_length;
    logic [EDGE_W-1:0] edge_number;
    logic [VOL_W-1:0]  volume;
    logic              volume_valid;
  } out_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } point_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              first;
    logic              sel;
    logic              sq;
    logic [AXIS_W-1:0] axis;
    logic              root;
    logic              put;
    logic              last_edge;
    logic [EDGE_W-1:0] edge_num;
  } cmd_t;

endpackage
`default_nettype wire

@@ sv/bve_datapath.sv @@
// Datapath: extreme point registers, squared distance, square root, product and output word.
`default_nettype none
module bve_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  bve_pkg::in_word_t   in_data,
  input  bve_pkg::cmd_t       cmd,
  output bve_pkg::out_word_t  out_data
);
  import bve_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int REM_W = ROOT_W + 3;
  localparam int CMP_W = (ROOT_W > LEN_W) ? ROOT_W : LEN_W;

  point_t min_x, max_x, min_y, max_y, min_z, max_z;
  point_t lo, hi;
  point_t pt;

  logic [D2_W-1:0]      v;
  logic [REM_W-1:0]     rem;
  logic [ROOT_W-1:0]    r;
  logic [2*LEN_W-1:0]   vol_prod;
  out_word_t            out_q;

  logic signed [CB:0]   ext_x, ext_y, ext_z;
  logic [AXIS_W-1:0]    best;
  logic [CB-1:0]        ca, cb;
  logic [CB:0]          diff, mag;
  logic [2*CB-1:0]      sq;
  logic [REM_W-1:0]     rem_sh, trial;
  logic [LEN_W-1:0]     len;
  logic [VOL_W-1:0]     full;

  assign pt.x = in_data.point_x;
  assign pt.y = in_data.point_y;
  assign pt.z = in_data.point_z;

  // extent of each axis, always >= 0 once the cloud has a point
  assign ext_x = $signed({max_x.x[CB-1], max_x.x}) - $signed({min_x.x[CB-1], min_x.x});
  assign ext_y = $signed({max_y.y[CB-1], max_y.y}) - $signed({min_y.y[CB-1], min_y.y});
  assign ext_z = $signed({max_z.z[CB-1], max_z.z}) - $signed({min_z.z[CB-1], min_z.z});

  always_comb begin
    logic signed [CB:0] be;
    best = AXIS_X;
    be   = ext_x;
    if (ext_y > be) begin
      best = AXIS_Y;
      be   = ext_y;
    end
    if (ext_z > be) begin
      best = AXIS_Z;
    end
  end

  always_comb begin
    case (cmd.axis)
      AXIS_X: begin
        ca = hi.x;
        cb = lo.x;
      end
      AXIS_Y: begin
        ca = hi.y;
        cb = lo.y;
      end
      default: begin
        ca = hi.z;
        cb = lo.z;
      end
    endcase
  end

  assign diff = {ca[CB-1], ca} - {cb[CB-1], cb};
  assign mag  = diff[CB] ? (~diff + 1'b1) : diff;
  assign sq   = mag[CB-1:0] * mag[CB-1:0];

  // one result bit per root step
  assign rem_sh = {rem[REM_W-3:0], v[D2_W-1 -: 2]};
  assign trial  = REM_W'({r, 2'b01});

  assign len  = (CMP_W'(r) > CMP_W'(LEN_MAX)) ? LEN_MAX : LEN_W'(r);
  assign full = VOL_W'(vol_prod * len);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cmd.first) begin
        min_x <= pt;
        max_x <= pt;
        min_y <= pt;
        max_y <= pt;
        min_z <= pt;
        max_z <= pt;
      end else begin
        if ($signed(pt.x) < $signed(min_x.x)) min_x <= pt;
        if ($signed(pt.x) > $signed(max_x.x)) max_x <= pt;
        if ($signed(pt.y) < $signed(min_y.y)) min_y <= pt;
        if ($signed(pt.y) > $signed(max_y.y)) max_y <= pt;
        if ($signed(pt.z) < $signed(min_z.z)) min_z <= pt;
        if ($signed(pt.z) > $signed(max_z.z)) max_z <= pt;
      end
    end

    if (cmd.sel) begin
      case (best)
        AXIS_X: begin
          lo <= min_x;
          hi <= max_x;
        end
        AXIS_Y: begin
          lo <= min_y;
          hi <= max_y;
        end
        default: begin
          lo <= min_z;
          hi <= max_z;
        end
      endcase
      v   <= '0;
      rem <= '0;
      r   <= '0;
    end else if (cmd.sq) begin
      v <= v + D2_W'(sq);
    end else if (cmd.root) begin
      v <= {v[D2_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        r   <= {r[ROOT_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        r   <= {r[ROOT_W-2:0], 1'b0};
      end
    end

    if (cmd.put) begin
      out_q.edge_length  <= len;
      out_q.edge_number  <= cmd.edge_num;
      out_q.volume       <= cmd.last_edge ? full : '0;
      out_q.volume_valid <= cmd.last_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_prod <= (2*LEN_W)'(1);
    end else if (cmd.put) begin
      vol_prod <= cmd.last_edge ? (2*LEN_W)'(1) : full[2*LEN_W-1:0];
    end
  end

  assign out_data = out_q;

endmodule
`default_nettype wire

@@ sv/bve_ctrl.sv @@
// Controller: sequencing of point intake, axis select, squaring, root steps and word output.
`default_nettype none
module bve_ctrl (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     last_point,
  output logic          out_valid,
  input  wire logic     out_ready,
  output bve_pkg::cmd_t cmd
);
  import bve_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEL  = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_PUT  = 3'd4;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [EDGE_W-1:0] edges_done;
  logic              first;
  logic              accept, out_free, put;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign put      = (state == ST_PUT) && out_free;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (accept && last_point) state_next = ST_SEL;
      end
      ST_SEL: begin
        cnt_next   = '0;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        if (cnt == CNT_W'(AXIS_Z)) begin
          cnt_next   = '0;
          state_next = ST_ROOT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_ROOT: begin
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          state_next = ST_PUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_PUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      edges_done <= '0;
      first      <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (accept) first <= 1'b0;
      if (put) begin
        first      <= 1'b1;
        edges_done <= (edges_done == LAST_EDGE) ? '0 : edges_done + 1'b1;
      end
      if (put) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd.load      = accept;
    cmd.first     = first;
    cmd.sel       = (state == ST_SEL);
    cmd.sq        = (state == ST_SQ);
    cmd.axis      = cnt[AXIS_W-1:0];
    cmd.root      = (state == ST_ROOT);
    cmd.put       = put;
    cmd.last_edge = (edges_done == LAST_EDGE);
    cmd.edge_num  = edges_done;
  end

  a_put_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUT && !out_free) |=> (state == ST_PUT && out_valid))
    else $error("result word dropped while output slot busy");

  a_root_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT && cnt == CNT_W'(ROOT_W - 1)) |=> (state == ST_PUT))
    else $error("root iteration count wrong");

  a_last_start: assert property (@(posedge clk) disable iff (rst)
    (accept && last_point) |=> (state == ST_SEL && !first))
    else $error("last point did not start edge evaluation");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    (put && edges_done == LAST_EDGE) |=> (edges_done == '0 && first && out_valid))
    else $error("edge counter did not wrap after third edge");

endmodule
`default_nettype wire

@@ sv/box_volume_from_edge_extents_top.sv @@
// Top level of the box volume block: controller plus datapath.
//
// Input channel (in_valid/in_ready/in_data) takes one point word per cycle
// when idle: signed x, y, z and last_point, closing the current edge cloud.
// Points that do not close a cloud are absorbed without leaving idle.
// A closing point starts an evaluation: a select state picks the widest axis,
// a single 16x16 squarer sums the squares over the three axes for the squared
// distance, and a one-bit-per-step square root unit takes its root. The result
// word is loaded into the output register in the put state after the last root
// step, and the input takes the next point the cycle after that.
// Output channel (out_valid/out_ready/out_data) carries one word per cloud:
// edge length, edge number, and for edge number 2 the volume with
// volume_valid set; then the edge count and running product start over.
// The output register holds its word while the receiver stalls; intake of
// plain points goes on meanwhile, and a finished evaluation waits for the slot.
// Synchronous reset clears the controller and the edge count and sets the product to one.
`default_nettype none
module box_volume_from_edge_extents_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  bve_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bve_pkg::out_word_t out_data
);
  import bve_pkg::*;

  cmd_t cmd;

  bve_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .last_point (in_data.last_point),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  bve_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
